// ===== rtl/core/mpts_pkg.sv =====
// Package with the constants, codes and sequencer states of the task scheduler.
package mpts_pkg;
	localparam int TASK_SLOTS = 16;
	localparam int LOCK_SLOTS = 8;
	localparam int TW = $clog2(TASK_SLOTS);
	localparam int LW = $clog2(LOCK_SLOTS);
	localparam int QDEPTH = TASK_SLOTS * LOCK_SLOTS;
	localparam int VRW = 48;
	localparam int RNDW = 31;

	localparam logic [2:0] KIND_LOAD = 3'd0;
	localparam logic [2:0] KIND_SET = 3'd1;
	localparam logic [2:0] KIND_SCHED = 3'd2;
	localparam logic [2:0] KIND_TICK = 3'd3;
	localparam logic [2:0] KIND_ACQ = 3'd4;
	localparam logic [2:0] KIND_REL = 3'd5;

	localparam logic [2:0] ST_READY = 3'd0;
	localparam logic [2:0] ST_RUNNING = 3'd1;
	localparam logic [2:0] ST_BLOCKED = 3'd2;
	localparam logic [2:0] ST_SLEEPING = 3'd3;
	localparam logic [2:0] ST_FINISHED = 3'd4;

	localparam logic [2:0] POL_RR = 3'd0;
	localparam logic [2:0] POL_PRIO = 3'd1;
	localparam logic [2:0] POL_FB = 3'd2;
	localparam logic [2:0] POL_LOT = 3'd3;
	localparam logic [2:0] POL_VR = 3'd4;

	localparam logic [1:0] TOP_LEVEL = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_BAD = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_TASKS = 2'd1;
	localparam logic [1:0] REG_LOCKS = 2'd2;
	localparam logic [1:0] REG_TICKETS = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_WAKE, S_SETUP, S_DIV, S_RR_INIT, S_PICK,
		S_RESOLVE, S_SWITCH, S_REL_WAKE, S_FINISH
	} seq_state_t;
endpackage

// ===== rtl/core/multi_policy_task_scheduler.sv =====
// Top level of the multi-policy task scheduler with lock wait queues.
//
// An item is transferred when start is high and busy is low; its fields are
// captured then. The block stays busy while a small sequencer works on it and
// then shows one result for one cycle with done high. The receiver cannot stall.
// A release with waiters adds a step that wakes the head waiter of the lock.
// Schedule wakes sleepers slot by slot, then picks slot by slot through a single
// shared compare path. Round robin first reduces its start slot; lottery first
// runs a bit-serial modulo of the random value by the ticket total. A tick skips
// the wake pass but has the same round robin and lottery steps. Configuration
// registers are written with cfg_we, cfg_index and cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Reset puts every task in the finished state, frees every lock and leaves no
// task running; the wait queue memory needs no clearing.
module multi_policy_task_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [3:0]  task_index,
	input  logic [2:0]  lock_index,
	input  logic [2:0]  state_code,
	input  logic [7:0]  priority_value,
	input  logic [7:0]  ticket_value,
	input  logic [31:0] now_us,
	input  logic [31:0] wake_time,
	input  logic [30:0] random_value,
	output logic        done,
	output logic [3:0]  chosen_task,
	output logic        switched,
	output logic        acquired,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int TW = mpts_pkg::TW;
	localparam int LW = mpts_pkg::LW;

	mpts_pkg::seq_state_t st_q, st_d;

	logic [2:0]  policy_q;
	logic [4:0]  tcount_q;
	logic [3:0]  lcount_q;
	logic [15:0] total_q;

	logic [2:0]  tstate_q [mpts_pkg::TASK_SLOTS];
	logic [7:0]  tprio_q [mpts_pkg::TASK_SLOTS];
	logic [7:0]  ttick_q [mpts_pkg::TASK_SLOTS];
	logic [1:0]  tlevel_q [mpts_pkg::TASK_SLOTS];
	logic [47:0] tvr_q [mpts_pkg::TASK_SLOTS];
	logic [31:0] tstart_q [mpts_pkg::TASK_SLOTS];
	logic [31:0] twake_q [mpts_pkg::TASK_SLOTS];
	logic [LW:0] tlock_q [mpts_pkg::TASK_SLOTS];
	logic [TW:0] running_q;

	logic            ltaken_q [mpts_pkg::LOCK_SLOTS];
	logic [TW-1:0]   lholder_q [mpts_pkg::LOCK_SLOTS];
	logic [TW-1:0]   lhead_q [mpts_pkg::LOCK_SLOTS];
	logic [TW:0]     lwcount_q [mpts_pkg::LOCK_SLOTS];
	logic [TW-1:0]   wq_mem [mpts_pkg::QDEPTH];
	logic [TW-1:0]   wq_rd_q;

	logic [2:0]  k_q;
	logic [3:0]  t_q;
	logic [2:0]  l_q;
	logic [2:0]  ns_q;
	logic [7:0]  pri_q;
	logic [7:0]  tk_q;
	logic [31:0] now_q;
	logic [31:0] wake_q;
	logic [30:0] div_q;
	logic [15:0] rem_q;
	logic [4:0]  idx_q;
	logic [4:0]  cnt_q;
	logic        rr_q;
	logic        has_q;
	logic [3:0]  best_q;
	logic [7:0]  bestp_q;
	logic [1:0]  bestlv_q;
	logic [47:0] minv_q;
	logic [12:0] sum_q;
	logic        sw_q, acq_q;
	logic [1:0]  stat_q;
	logic        done_q;
	logic [3:0]  chosen_q;

	logic [4:0]  n_w;
	logic [3:0]  live_l_w;
	logic [3:0]  si;
	logic        rdy_w;
	logic [12:0] sum_nx;
	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic        last_w;
	logic        lock_ok_w;
	logic [4:0]  rr_start_w;
	logic [31:0] run_diff;
	logic [48:0] vr_sum;
	logic [3:0]  prev_w;
	logic [LW+TW-1:0] wr_addr;
	logic [LW+TW-1:0] rd_addr;
	logic [3:0]  wi;

	assign n_w = (tcount_q > 5'(mpts_pkg::TASK_SLOTS)) ? 5'(mpts_pkg::TASK_SLOTS) : tcount_q;
	assign live_l_w = (lcount_q > 4'(mpts_pkg::LOCK_SLOTS)) ? 4'(mpts_pkg::LOCK_SLOTS)
		: lcount_q;
	assign si = idx_q[TW-1:0];
	assign rdy_w = (tstate_q[si] == mpts_pkg::ST_READY);
	assign sum_nx = sum_q + 13'(ttick_q[si]);
	assign rem_sh = {rem_q, div_q[30]};
	assign rem_sub = rem_sh - {1'b0, total_q};
	assign last_w = rr_q ? (cnt_q + 5'd1 == n_w) : (idx_q + 5'd1 == n_w);
	assign lock_ok_w = ({1'b0, l_q} < live_l_w);
	assign rr_start_w = running_q[TW] ? 5'd0 : running_q + 5'd1;
	assign prev_w = running_q[TW-1:0];
	assign run_diff = now_q - tstart_q[prev_w];
	assign vr_sum = {1'b0, tvr_q[prev_w]} + {17'd0, run_diff};
	assign wr_addr = {l_q, lhead_q[l_q] + lwcount_q[l_q][TW-1:0]};
	assign rd_addr = {l_q, lhead_q[l_q]};
	assign wi = wq_rd_q;

	assign busy = (st_q != mpts_pkg::S_IDLE);
	assign done = done_q;
	assign chosen_task = chosen_q;
	assign switched = sw_q;
	assign acquired = acq_q;
	assign status = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mpts_pkg::S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			mpts_pkg::S_IDLE: begin
				if (start) st_d = mpts_pkg::S_EXEC;
			end
			mpts_pkg::S_EXEC: begin
				if (k_q == mpts_pkg::KIND_SCHED) begin
					st_d = (n_w == 5'd0) ? mpts_pkg::S_SETUP : mpts_pkg::S_WAKE;
				end else if (k_q == mpts_pkg::KIND_TICK && !running_q[TW]) begin
					st_d = mpts_pkg::S_SETUP;
				end else if (k_q == mpts_pkg::KIND_REL && lock_ok_w && ltaken_q[l_q]
					&& lholder_q[l_q] == t_q && lwcount_q[l_q] != '0) begin
					st_d = mpts_pkg::S_REL_WAKE;
				end else begin
					st_d = mpts_pkg::S_FINISH;
				end
			end
			mpts_pkg::S_WAKE: begin
				if (idx_q + 5'd1 == n_w) st_d = mpts_pkg::S_SETUP;
			end
			mpts_pkg::S_SETUP: begin
				if (n_w == 5'd0) st_d = mpts_pkg::S_RESOLVE;
				else if (policy_q == mpts_pkg::POL_LOT && total_q != '0) st_d = mpts_pkg::S_DIV;
				else if (policy_q == mpts_pkg::POL_PRIO || policy_q == mpts_pkg::POL_FB
					|| policy_q == mpts_pkg::POL_VR) st_d = mpts_pkg::S_PICK;
				else st_d = mpts_pkg::S_RR_INIT;
			end
			mpts_pkg::S_DIV: begin
				if (cnt_q == 5'd30) st_d = mpts_pkg::S_PICK;
			end
			mpts_pkg::S_RR_INIT: begin
				if (idx_q < n_w) st_d = mpts_pkg::S_PICK;
			end
			mpts_pkg::S_PICK: begin
				if (last_w || (rr_q && rdy_w)) st_d = mpts_pkg::S_RESOLVE;
			end
			mpts_pkg::S_RESOLVE: begin
				if (has_q && (k_q == mpts_pkg::KIND_SCHED || {1'b0, best_q} != running_q))
					st_d = mpts_pkg::S_SWITCH;
				else st_d = mpts_pkg::S_FINISH;
			end
			mpts_pkg::S_SWITCH: st_d = mpts_pkg::S_FINISH;
			mpts_pkg::S_REL_WAKE: st_d = mpts_pkg::S_FINISH;
			mpts_pkg::S_FINISH: st_d = mpts_pkg::S_IDLE;
			default: st_d = mpts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == mpts_pkg::S_EXEC && k_q == mpts_pkg::KIND_ACQ && lock_ok_w
			&& ltaken_q[l_q] && lwcount_q[l_q] < 5'(mpts_pkg::TASK_SLOTS)) begin
			wq_mem[wr_addr] <= t_q;
		end
		wq_rd_q <= wq_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (st_q == mpts_pkg::S_IDLE && start) begin
			k_q <= kind;
			t_q <= task_index;
			l_q <= lock_index;
			ns_q <= state_code;
			pri_q <= priority_value;
			tk_q <= ticket_value;
			now_q <= now_us;
			wake_q <= wake_time;
			div_q <= random_value;
		end else if (st_q == mpts_pkg::S_DIV) begin
			div_q <= {div_q[29:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= mpts_pkg::POL_FB;
			tcount_q <= '0;
			lcount_q <= '0;
			total_q <= '0;
			for (int i = 0; i < mpts_pkg::TASK_SLOTS; i++) begin
				tstate_q[i] <= mpts_pkg::ST_FINISHED;
				tprio_q[i] <= '0;
				ttick_q[i] <= '0;
				tlevel_q[i] <= '0;
				tvr_q[i] <= '0;
				tstart_q[i] <= '0;
				twake_q[i] <= '0;
				tlock_q[i] <= (LW+1)'(mpts_pkg::LOCK_SLOTS);
			end
			for (int j = 0; j < mpts_pkg::LOCK_SLOTS; j++) begin
				ltaken_q[j] <= 1'b0;
				lholder_q[j] <= '0;
				lhead_q[j] <= '0;
				lwcount_q[j] <= '0;
			end
			running_q <= (TW+1)'(mpts_pkg::TASK_SLOTS);
			idx_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			rr_q <= 1'b0;
			has_q <= 1'b0;
			best_q <= '0;
			bestp_q <= '0;
			bestlv_q <= '0;
			minv_q <= '0;
			sum_q <= '0;
			sw_q <= 1'b0;
			acq_q <= 1'b0;
			stat_q <= mpts_pkg::STAT_OK;
			done_q <= 1'b0;
			chosen_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					mpts_pkg::REG_POLICY: policy_q <= cfg_data[2:0];
					mpts_pkg::REG_TASKS: tcount_q <= cfg_data[4:0];
					mpts_pkg::REG_LOCKS: lcount_q <= cfg_data[3:0];
					mpts_pkg::REG_TICKETS: total_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				mpts_pkg::S_IDLE: begin
					sw_q <= 1'b0;
					acq_q <= 1'b0;
					stat_q <= mpts_pkg::STAT_OK;
					idx_q <= '0;
					cnt_q <= '0;
					has_q <= 1'b0;
					sum_q <= '0;
					rem_q <= '0;
				end
				mpts_pkg::S_EXEC: begin
					case (k_q)
						mpts_pkg::KIND_LOAD: begin
							if ({1'b0, t_q} < n_w) begin
								tstate_q[t_q] <= mpts_pkg::ST_READY;
								tprio_q[t_q] <= pri_q;
								ttick_q[t_q] <= tk_q;
								tlevel_q[t_q] <= '0;
								tvr_q[t_q] <= '0;
								tstart_q[t_q] <= '0;
								twake_q[t_q] <= '0;
								tlock_q[t_q] <= (LW+1)'(mpts_pkg::LOCK_SLOTS);
								if (running_q == {1'b0, t_q})
									running_q <= (TW+1)'(mpts_pkg::TASK_SLOTS);
							end
						end
						mpts_pkg::KIND_SET: begin
							if ({1'b0, t_q} < n_w && ns_q <= mpts_pkg::ST_FINISHED) begin
								tstate_q[t_q] <= ns_q;
								if (ns_q == mpts_pkg::ST_SLEEPING) twake_q[t_q] <= wake_q;
							end
						end
						mpts_pkg::KIND_TICK: begin
							if (!running_q[TW] && policy_q == mpts_pkg::POL_FB
								&& tlevel_q[prev_w] < mpts_pkg::TOP_LEVEL)
								tlevel_q[prev_w] <= tlevel_q[prev_w] + 2'd1;
						end
						mpts_pkg::KIND_ACQ: begin
							if (!lock_ok_w) begin
								stat_q <= mpts_pkg::STAT_BAD;
							end else if (!ltaken_q[l_q]) begin
								ltaken_q[l_q] <= 1'b1;
								lholder_q[l_q] <= t_q;
								acq_q <= 1'b1;
							end else if (lwcount_q[l_q] >= 5'(mpts_pkg::TASK_SLOTS)) begin
								stat_q <= mpts_pkg::STAT_FULL;
							end else begin
								lwcount_q[l_q] <= lwcount_q[l_q] + 5'd1;
								tlock_q[t_q] <= {1'b0, l_q};
								tstate_q[t_q] <= mpts_pkg::ST_BLOCKED;
							end
						end
						mpts_pkg::KIND_REL: begin
							if (!lock_ok_w || !ltaken_q[l_q] || lholder_q[l_q] != t_q) begin
								stat_q <= mpts_pkg::STAT_BAD;
							end else begin
								ltaken_q[l_q] <= 1'b0;
								lholder_q[l_q] <= '0;
							end
						end
						default: ;
					endcase
				end
				mpts_pkg::S_WAKE: begin
					if (tstate_q[si] == mpts_pkg::ST_SLEEPING && now_q >= twake_q[si]) begin
						tstate_q[si] <= mpts_pkg::ST_READY;
						twake_q[si] <= '0;
					end
					idx_q <= (idx_q + 5'd1 == n_w) ? 5'd0 : idx_q + 5'd1;
				end
				mpts_pkg::S_SETUP: begin
					rr_q <= !(policy_q == mpts_pkg::POL_PRIO || policy_q == mpts_pkg::POL_FB
						|| policy_q == mpts_pkg::POL_VR
						|| (policy_q == mpts_pkg::POL_LOT && total_q != '0));
					idx_q <= (policy_q == mpts_pkg::POL_PRIO || policy_q == mpts_pkg::POL_FB
						|| policy_q == mpts_pkg::POL_VR || policy_q == mpts_pkg::POL_LOT)
						&& !(policy_q == mpts_pkg::POL_LOT && total_q == '0) ? 5'd0 : rr_start_w;
					cnt_q <= '0;
				end
				mpts_pkg::S_DIV: begin
					rem_q <= rem_sub[16] ? rem_sh[15:0] : rem_sub[15:0];
					cnt_q <= (cnt_q == 5'd30) ? 5'd0 : cnt_q + 5'd1;
				end
				mpts_pkg::S_RR_INIT: begin
					if (idx_q >= n_w) idx_q <= idx_q - n_w;
				end
				mpts_pkg::S_PICK: begin
					if (rr_q) begin
						if (rdy_w) begin
							has_q <= 1'b1;
							best_q <= si;
						end
						idx_q <= (idx_q + 5'd1 == n_w) ? 5'd0 : idx_q + 5'd1;
						cnt_q <= cnt_q + 5'd1;
					end else begin
						idx_q <= idx_q + 5'd1;
						if (rdy_w) begin
							case (policy_q)
								mpts_pkg::POL_PRIO: begin
									if (!has_q || tprio_q[si] > bestp_q) begin
										has_q <= 1'b1;
										best_q <= si;
										bestp_q <= tprio_q[si];
									end
								end
								mpts_pkg::POL_FB: begin
									if (tlevel_q[si] <= mpts_pkg::TOP_LEVEL
										&& (!has_q || tlevel_q[si] < bestlv_q)) begin
										has_q <= 1'b1;
										best_q <= si;
										bestlv_q <= tlevel_q[si];
									end
								end
								mpts_pkg::POL_VR: begin
									if (!has_q || tvr_q[si] < minv_q) begin
										has_q <= 1'b1;
										best_q <= si;
										minv_q <= tvr_q[si];
									end
								end
								default: begin
									sum_q <= sum_nx;
									if (!has_q && {3'd0, sum_nx} > rem_q) begin
										has_q <= 1'b1;
										best_q <= si;
									end
								end
							endcase
						end
					end
				end
				mpts_pkg::S_RESOLVE: begin
					if (!has_q) stat_q <= mpts_pkg::STAT_NONE;
				end
				mpts_pkg::S_SWITCH: begin
					if (!running_q[TW] && tstate_q[prev_w] == mpts_pkg::ST_RUNNING) begin
						tvr_q[prev_w] <= vr_sum[48] ? '1 : vr_sum[47:0];
						tstate_q[prev_w] <= mpts_pkg::ST_READY;
					end
					running_q <= {1'b0, best_q};
					tstate_q[best_q] <= mpts_pkg::ST_RUNNING;
					tstart_q[best_q] <= now_q;
					sw_q <= 1'b1;
				end
				mpts_pkg::S_REL_WAKE: begin
					lhead_q[l_q] <= lhead_q[l_q] + 4'd1;
					lwcount_q[l_q] <= lwcount_q[l_q] - 5'd1;
					if (tstate_q[wi] == mpts_pkg::ST_BLOCKED && tlock_q[wi] == {1'b0, l_q}) begin
						tstate_q[wi] <= mpts_pkg::ST_READY;
						tlock_q[wi] <= (LW+1)'(mpts_pkg::LOCK_SLOTS);
					end
				end
				mpts_pkg::S_FINISH: begin
					done_q <= 1'b1;
					chosen_q <= running_q[TW] ? 4'd0 : running_q[TW-1:0];
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not make the block busy");
	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && switched |-> status == mpts_pkg::STAT_OK && !acquired)
		else $error("switch reported with an error status");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe lasted more than one cycle");
`endif
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the multi-policy task scheduler with lock wait queues.
`timescale 1ns / 100ps

module testbench;
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam logic [4:0] NO_TASK = 5'd16;
	localparam logic [3:0] NO_LOCK = 4'd8;
	localparam logic [47:0] VR_LIMIT = 48'hFFFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  task_idx;
		logic [2:0]  lock_idx;
		logic [2:0]  state_code;
		logic [7:0]  prio;
		logic [7:0]  tickets;
		logic [31:0] now;
		logic [31:0] wake;
		logic [30:0] rnd;
	} sched_item_t;

	typedef struct {
		logic [3:0] chosen;
		logic       sw;
		logic       acq;
		logic [1:0] stat;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] kind = '0;
	logic [3:0] task_index = '0;
	logic [2:0] lock_index = '0;
	logic [2:0] state_code = '0;
	logic [7:0] priority_value = '0;
	logic [7:0] ticket_value = '0;
	logic [31:0] now_us = '0;
	logic [31:0] wake_time = '0;
	logic [30:0] random_value = '0;
	logic done;
	logic [3:0] chosen_task;
	logic switched;
	logic acquired;
	logic [1:0] status;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	multi_policy_task_scheduler u_top (.*);

	always #4 clk = ~clk;

	// Scheduler mirror state.
	logic [2:0]  pol;
	logic [4:0]  n_tasks_cfg;
	logic [3:0]  n_locks_cfg;
	logic [15:0] lottery_total;
	logic [2:0]  t_state [mpts_pkg::TASK_SLOTS];
	logic [7:0]  t_prio [mpts_pkg::TASK_SLOTS];
	logic [7:0]  t_tickets [mpts_pkg::TASK_SLOTS];
	logic [1:0]  t_level [mpts_pkg::TASK_SLOTS];
	logic [47:0] t_vrun [mpts_pkg::TASK_SLOTS];
	logic [31:0] t_run_start [mpts_pkg::TASK_SLOTS];
	logic [31:0] t_wake [mpts_pkg::TASK_SLOTS];
	logic [3:0]  t_awaits [mpts_pkg::TASK_SLOTS];
	logic [4:0]  cur_task;
	logic        l_taken [mpts_pkg::LOCK_SLOTS];
	logic [3:0]  l_holder [mpts_pkg::LOCK_SLOTS];
	logic [3:0]  l_queue [mpts_pkg::LOCK_SLOTS][mpts_pkg::TASK_SLOTS];
	logic [4:0]  l_waiters [mpts_pkg::LOCK_SLOTS];

	sched_result_t awaited_results[$];
	int mismatches = 0;
	int cycles = 0;
	int sender_idle_pct = 0;
	logic [31:0] clock_us = 0;

	function automatic int live_tasks();
		return (n_tasks_cfg > mpts_pkg::TASK_SLOTS) ? mpts_pkg::TASK_SLOTS : int'(n_tasks_cfg);
	endfunction

	function automatic int live_locks();
		return (n_locks_cfg > mpts_pkg::LOCK_SLOTS) ? mpts_pkg::LOCK_SLOTS : int'(n_locks_cfg);
	endfunction

	function automatic void mirror_reset();
		pol = mpts_pkg::POL_FB;
		n_tasks_cfg = 0;
		n_locks_cfg = 0;
		lottery_total = 0;
		for (int i = 0; i < mpts_pkg::TASK_SLOTS; i++) begin
			t_state[i] = mpts_pkg::ST_FINISHED;
			t_prio[i] = 0;
			t_tickets[i] = 0;
			t_level[i] = 0;
			t_vrun[i] = 0;
			t_run_start[i] = 0;
			t_wake[i] = 0;
			t_awaits[i] = NO_LOCK;
		end
		cur_task = NO_TASK;
		for (int i = 0; i < mpts_pkg::LOCK_SLOTS; i++) begin
			l_taken[i] = 0;
			l_holder[i] = 0;
			l_waiters[i] = 0;
		end
	endfunction

	function automatic int rr_pick(int n);
		int first;
		int idx;
		first = (cur_task < mpts_pkg::TASK_SLOTS) ? int'(cur_task) + 1 : 0;
		for (int i = 0; i < n; i++) begin
			idx = (first + i) % n;
			if (t_state[idx] == mpts_pkg::ST_READY)
				return idx;
		end
		return mpts_pkg::TASK_SLOTS;
	endfunction

	function automatic int pick_task(logic [30:0] rnd);
		int n;
		int best;
		int bestp;
		logic [31:0] win;
		logic [31:0] sum;
		n = live_tasks();
		best = mpts_pkg::TASK_SLOTS;
		bestp = -1;
		sum = 0;
		if (n == 0)
			return mpts_pkg::TASK_SLOTS;
		case (pol)
			mpts_pkg::POL_PRIO: begin
				for (int i = 0; i < n; i++)
					if (t_state[i] == mpts_pkg::ST_READY && int'(t_prio[i]) > bestp) begin
						bestp = t_prio[i];
						best = i;
					end
				return best;
			end
			mpts_pkg::POL_FB: begin
				for (int lv = 0; lv <= mpts_pkg::TOP_LEVEL; lv++)
					for (int i = 0; i < n; i++)
						if (t_state[i] == mpts_pkg::ST_READY && t_level[i] == lv)
							return i;
				return mpts_pkg::TASK_SLOTS;
			end
			mpts_pkg::POL_LOT: begin
				if (lottery_total == 0)
					return rr_pick(n);
				win = {1'b0, rnd} % {16'b0, lottery_total};
				for (int i = 0; i < n; i++)
					if (t_state[i] == mpts_pkg::ST_READY) begin
						sum = sum + t_tickets[i];
						if (sum > win)
							return i;
					end
				return mpts_pkg::TASK_SLOTS;
			end
			mpts_pkg::POL_VR: begin
				for (int i = 0; i < n; i++)
					if (t_state[i] == mpts_pkg::ST_READY &&
					    (best == mpts_pkg::TASK_SLOTS || t_vrun[i] < t_vrun[best]))
						best = i;
				return best;
			end
			default: return rr_pick(n);
		endcase
	endfunction

	function automatic void switch_task(int nxt, logic [31:0] now);
		logic [31:0] span;
		logic [63:0] total;
		if (cur_task < mpts_pkg::TASK_SLOTS && t_state[cur_task] == mpts_pkg::ST_RUNNING) begin
			span = now - t_run_start[cur_task];
			total = {16'b0, t_vrun[cur_task]} + {32'b0, span};
			t_vrun[cur_task] = (total > {16'b0, VR_LIMIT}) ? VR_LIMIT : total[47:0];
			t_state[cur_task] = mpts_pkg::ST_READY;
		end
		cur_task = 5'(nxt);
		t_state[nxt] = mpts_pkg::ST_RUNNING;
		t_run_start[nxt] = now;
	endfunction

	function automatic sched_result_t predict_scheduler(sched_item_t it);
		sched_result_t r;
		int n;
		int nxt;
		int t;
		int l;
		int w;
		n = live_tasks();
		t = it.task_idx;
		l = it.lock_idx;
		r.sw = 0;
		r.acq = 0;
		r.stat = mpts_pkg::STAT_OK;
		case (it.kind)
			mpts_pkg::KIND_LOAD: if (t < n) begin
				t_state[t] = mpts_pkg::ST_READY;
				t_prio[t] = it.prio;
				t_tickets[t] = it.tickets;
				t_level[t] = 0;
				t_vrun[t] = 0;
				t_run_start[t] = 0;
				t_wake[t] = 0;
				t_awaits[t] = NO_LOCK;
				if (cur_task == t)
					cur_task = NO_TASK;
			end
			mpts_pkg::KIND_SET: if (t < n && it.state_code <= mpts_pkg::ST_FINISHED) begin
				t_state[t] = it.state_code;
				if (it.state_code == mpts_pkg::ST_SLEEPING)
					t_wake[t] = it.wake;
			end
			mpts_pkg::KIND_SCHED: begin
				for (int i = 0; i < n; i++)
					if (t_state[i] == mpts_pkg::ST_SLEEPING && it.now >= t_wake[i]) begin
						t_state[i] = mpts_pkg::ST_READY;
						t_wake[i] = 0;
					end
				nxt = pick_task(it.rnd);
				if (nxt >= mpts_pkg::TASK_SLOTS)
					r.stat = mpts_pkg::STAT_NONE;
				else begin
					switch_task(nxt, it.now);
					r.sw = 1;
				end
			end
			mpts_pkg::KIND_TICK: if (cur_task < mpts_pkg::TASK_SLOTS) begin
				if (pol == mpts_pkg::POL_FB && t_level[cur_task] < mpts_pkg::TOP_LEVEL)
					t_level[cur_task] = t_level[cur_task] + 1;
				nxt = pick_task(it.rnd);
				if (nxt >= mpts_pkg::TASK_SLOTS)
					r.stat = mpts_pkg::STAT_NONE;
				else if (nxt != cur_task) begin
					switch_task(nxt, it.now);
					r.sw = 1;
				end
			end
			mpts_pkg::KIND_ACQ: begin
				if (l >= live_locks())
					r.stat = mpts_pkg::STAT_BAD;
				else if (!l_taken[l]) begin
					l_taken[l] = 1;
					l_holder[l] = 4'(t);
					r.acq = 1;
				end else if (l_waiters[l] >= mpts_pkg::TASK_SLOTS)
					r.stat = mpts_pkg::STAT_FULL;
				else begin
					l_queue[l][l_waiters[l]] = 4'(t);
					l_waiters[l] = l_waiters[l] + 1;
					t_awaits[t] = 4'(l);
					t_state[t] = mpts_pkg::ST_BLOCKED;
				end
			end
			mpts_pkg::KIND_REL: begin
				if (l >= live_locks() || !l_taken[l] || l_holder[l] != t)
					r.stat = mpts_pkg::STAT_BAD;
				else begin
					l_taken[l] = 0;
					l_holder[l] = 0;
					if (l_waiters[l] > 0) begin
						w = l_queue[l][0];
						for (int i = 1; i < l_waiters[l]; i++)
							l_queue[l][i - 1] = l_queue[l][i];
						l_waiters[l] = l_waiters[l] - 1;
						if (t_state[w] == mpts_pkg::ST_BLOCKED && t_awaits[w] == l) begin
							t_state[w] = mpts_pkg::ST_READY;
							t_awaits[w] = NO_LOCK;
						end
					end
				end
			end
			default: ;
		endcase
		r.chosen = (cur_task < mpts_pkg::TASK_SLOTS) ? cur_task[3:0] : 4'd0;
		return r;
	endfunction

	function automatic sched_item_t make_item(logic [2:0] k, logic [3:0] t, logic [2:0] l,
			logic [2:0] ns, logic [31:0] now, logic [31:0] wake);
		sched_item_t it;
		it.kind = k;
		it.task_idx = t;
		it.lock_idx = l;
		it.state_code = ns;
		it.prio = 8'($urandom);
		it.tickets = 8'($urandom);
		it.now = now;
		it.wake = wake;
		it.rnd = 31'($urandom);
		return it;
	endfunction

	task automatic send_item(sched_item_t it);
		if ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start = 1'b1;
		kind = it.kind;
		task_index = it.task_idx;
		lock_index = it.lock_idx;
		state_code = it.state_code;
		priority_value = it.prio;
		ticket_value = it.tickets;
		now_us = it.now;
		wake_time = it.wake;
		random_value = it.rnd;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		awaited_results.push_back(predict_scheduler(it));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_idle();
		while (awaited_results.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned value);
		logic [15:0] data;
		wait_idle();
		case (idx)
			mpts_pkg::REG_POLICY: data = (16'($urandom) & 16'hFFF8) | 16'(value);
			mpts_pkg::REG_TASKS: data = (16'($urandom) & 16'hFFE0) | 16'(value);
			mpts_pkg::REG_LOCKS: data = (16'($urandom) & 16'hFFF0) | 16'(value);
			default: data = 16'(value);
		endcase
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			mpts_pkg::REG_POLICY: pol = data[2:0];
			mpts_pkg::REG_TASKS: n_tasks_cfg = data[4:0];
			mpts_pkg::REG_LOCKS: n_locks_cfg = data[3:0];
			default: lottery_total = data;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int unsigned p, int unsigned nt, int unsigned nl, int unsigned tt);
		write_reg(mpts_pkg::REG_POLICY, p);
		write_reg(mpts_pkg::REG_TASKS, nt);
		write_reg(mpts_pkg::REG_LOCKS, nl);
		write_reg(mpts_pkg::REG_TICKETS, tt);
	endtask

	task automatic report_mismatch(string what, sched_result_t exp_r, sched_result_t act_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected task %0d sw %0d acq %0d status %0d, got task %0d sw %0d acq %0d status %0d",
				$realtime, what, exp_r.chosen, exp_r.sw, exp_r.acq, exp_r.stat,
				act_r.chosen, act_r.sw, act_r.acq, act_r.stat);
	endtask

	always @(posedge clk) begin
		sched_result_t act_r;
		sched_result_t exp_r;
		if (arst_n && done) begin
			act_r.chosen = chosen_task;
			act_r.sw = switched;
			act_r.acq = acquired;
			act_r.stat = status;
			if (awaited_results.size() == 0) begin
				exp_r = '{default: 'x};
				report_mismatch("unexpected result", exp_r, act_r);
			end else begin
				exp_r = awaited_results.pop_front();
				if (act_r.chosen !== exp_r.chosen || act_r.sw !== exp_r.sw ||
				    act_r.acq !== exp_r.acq || act_r.stat !== exp_r.stat)
					report_mismatch("result mismatch", exp_r, act_r);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_basic_ops();
		configure(mpts_pkg::POL_RR, 4, 2, 0);
		for (int i = 0; i < 4; i++)
			send_item(make_item(mpts_pkg::KIND_LOAD, 4'(i), 0, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_LOAD, 4'd15, 0, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_SCHED, 0, 0, 0, 32'd100, 0));
		send_item(make_item(mpts_pkg::KIND_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0));
		send_item(make_item(mpts_pkg::KIND_SET, 4'd2, 0, mpts_pkg::ST_SLEEPING, 0, 32'd500));
		send_item(make_item(mpts_pkg::KIND_SET, 4'd3, 0, KIND_SPARE_HI, 0, 0));
		send_item(make_item(mpts_pkg::KIND_SCHED, 0, 0, 0, 32'd600, 0));
		send_item(make_item(mpts_pkg::KIND_ACQ, 4'd2, 3'd1, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_ACQ, 4'd3, 3'd1, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_REL, 4'd3, 3'd1, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_REL, 4'd2, 3'd1, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_ACQ, 4'd15, 3'd7, 0, 0, 0));
		send_item(make_item(KIND_SPARE_LO, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_SPARE_HI, 4'd15, 3'd7, 3'd7, 0, 0));
		for (int i = 0; i < 4; i++)
			send_item(make_item(mpts_pkg::KIND_SET, 4'(i), 0, mpts_pkg::ST_FINISHED, 0, 0));
		send_item(make_item(mpts_pkg::KIND_SCHED, 0, 0, 0, 0, 0));
	endtask

	task automatic test_queue_full();
		configure(mpts_pkg::POL_PRIO, 31, 15, 65535);
		send_item(make_item(mpts_pkg::KIND_ACQ, 4'd0, 3'd7, 0, 0, 0));
		for (int i = 0; i <= mpts_pkg::TASK_SLOTS; i++)
			send_item(make_item(mpts_pkg::KIND_ACQ, 4'($urandom), 3'd7, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_REL, 4'd0, 3'd7, 0, 0, 0));
	endtask

	task automatic test_empty_table();
		configure(mpts_pkg::POL_VR, 0, 0, 1);
		send_item(make_item(mpts_pkg::KIND_SCHED, 0, 0, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(mpts_pkg::KIND_LOAD, 0, 0, 0, 0, 0));
	endtask

	task automatic run_random_items(int count);
		sched_item_t it;
		int sel;
		for (int n = 0; n < count; n++) begin
			clock_us = clock_us + $urandom_range(0, 60);
			it = make_item(mpts_pkg::KIND_SCHED, 4'($urandom), 3'($urandom),
				3'($urandom_range(0, 4)),
				($urandom_range(99) < 3) ? $urandom : clock_us,
				($urandom_range(99) < 5) ? $urandom : clock_us + $urandom_range(0, 300));
			sel = $urandom_range(99);
			if (sel < 14) it.kind = mpts_pkg::KIND_LOAD;
			else if (sel < 28) begin
				it.kind = mpts_pkg::KIND_SET;
				if ($urandom_range(99) < 5) it.state_code = 3'($urandom);
			end else if (sel < 52) it.kind = mpts_pkg::KIND_SCHED;
			else if (sel < 68) it.kind = mpts_pkg::KIND_TICK;
			else if (sel < 82) it.kind = mpts_pkg::KIND_ACQ;
			else if (sel < 98) begin
				it.kind = mpts_pkg::KIND_REL;
				if ($urandom_range(99) < 70) it.task_idx = l_holder[it.lock_idx];
			end else it.kind = 3'($urandom);
			if ($urandom_range(99) < 70 && it.kind != mpts_pkg::KIND_REL && live_tasks() > 0)
				it.task_idx = 4'($urandom_range(0, live_tasks() - 1));
			send_item(it);
		end
	endtask

	task automatic test_random_policies();
		int unsigned tt;
		for (int ph = 0; ph < 11; ph++) begin
			sender_idle_pct = (ph < 4) ? 8 : (ph < 8) ? 54 : 0;
			tt = (ph == 3) ? 65535 : (ph == 7) ? 0 : $urandom_range(1, 2000);
			configure((ph == 10) ? 7 : ph % 6, (ph == 9) ? 31 : (ph == 5) ? 3 : 16,
				(ph == 9) ? 15 : (ph == 6) ? 1 : 8, tt);
			run_random_items(100);
		end
	endtask

	initial begin
		mirror_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_basic_ops();
		test_queue_full();
		test_empty_table();
		test_random_policies();
		wait_idle();
		repeat (100) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/mpts_pkg.sv
rtl/core/multi_policy_task_scheduler.sv
verif/testbench.sv
